/* design/ps2mc_pkg.sv */
// Shared types and constants for the PS/2 mouse packet cursor block.
// Holds the framing phase codes, packet struct and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ps2mc_pkg;

  // Default coordinate register width.
  localparam int COORD_BITS_DEF = 16;

  // Field widths fixed by the interface.
  localparam int BYTE_BITS  = 8;
  localparam int SIZE_BITS  = 16;
  localparam int CURSOR_BITS = 16;
  localparam int CFG_INDEX_BITS = 1;
  localparam int MAG_BITS = 9;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST  = 16'd1024;
  localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST = 16'd768;

  // Header byte bit positions.
  localparam int HDR_BTN_LEFT   = 0;
  localparam int HDR_BTN_RIGHT  = 1;
  localparam int HDR_BTN_MIDDLE = 2;
  localparam int HDR_SYNC       = 3;
  localparam int HDR_X_SIGN     = 4;
  localparam int HDR_Y_SIGN     = 5;
  localparam int HDR_X_OVF      = 6;
  localparam int HDR_Y_OVF      = 7;

  // Extra movement added when an overflow bit is set.
  localparam logic [MAG_BITS-1:0] OVF_EXTRA = 9'd255;

  // Packet framing phase.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XMOVE  = 2'd1,
    PH_YMOVE  = 2'd2
  } phase_t;

  // Packet held by the framer until the next byte transfer.
  typedef struct packed {
    logic                 pending;
    logic [BYTE_BITS-1:0] header;
    logic [BYTE_BITS-1:0] x_move;
    logic [BYTE_BITS-1:0] y_move;
  } packet_t;

endpackage

/* design/ps2mc_framer.sv */
// Byte framer: gathers header, X and Y bytes into a pending packet.
// Depends on ps2mc_pkg for the phase enum and packet struct.
`timescale 1ns / 1ps

module ps2mc_framer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic [ps2mc_pkg::BYTE_BITS-1:0] rx_byte,
  output ps2mc_pkg::packet_t         packet
);
  import ps2mc_pkg::*;

  phase_t  phase_r, phase_nxt;
  packet_t pkt_r, pkt_nxt;

  // Phase and packet registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pkt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pkt_r   <= pkt_nxt;
    end
  end

  // Next phase and packet contents. A pending packet is consumed by every
  // transfer, so pending follows whether this byte completes a packet.
  always_comb begin
    phase_nxt = phase_r;
    pkt_nxt   = pkt_r;
    if (accept) begin
      pkt_nxt.pending = 1'b0;
      case (phase_r)
        PH_XMOVE: begin
          pkt_nxt.x_move = rx_byte;
          phase_nxt      = PH_YMOVE;
        end
        PH_YMOVE: begin
          pkt_nxt.y_move  = rx_byte;
          pkt_nxt.pending = 1'b1;
          phase_nxt       = PH_HEADER;
        end
        default: begin
          if (rx_byte[HDR_SYNC]) begin
            pkt_nxt.header = rx_byte;
            phase_nxt      = PH_XMOVE;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
      endcase
    end
  end

  assign packet = pkt_r;

endmodule

/* design/ps2mc_axis.sv */
// One cursor axis: sign-magnitude delta, move and clamp.
// Depends on ps2mc_pkg for field widths and the overflow constant.
`timescale 1ns / 1ps

module ps2mc_axis #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]            pos,
  input  logic [ps2mc_pkg::BYTE_BITS-1:0]  move_byte,
  input  logic                             sign_bit,
  input  logic                             ovf_bit,
  input  logic                             invert,
  input  logic [ps2mc_pkg::SIZE_BITS-1:0]  size,
  output logic [COORD_BITS-1:0]            pos_next
);
  import ps2mc_pkg::*;

  localparam int BASE_BITS = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int W = BASE_BITS + 2;

  logic [BYTE_BITS-1:0] base_mag;
  logic [MAG_BITS-1:0]  mag;
  logic                 subtract;
  logic [W-1:0]         pos_ext;
  logic [W-1:0]         sum;
  logic [W-1:0]         top;
  logic [W-1:0]         size_m1;
  logic [W-1:0]         clamped;

  // Magnitude: negative bytes are two's complement, so a zero byte stays zero.
  always_comb begin
    base_mag = sign_bit ? (BYTE_BITS'(0) - move_byte) : move_byte;
    mag      = {1'b0, base_mag} + (ovf_bit ? OVF_EXTRA : MAG_BITS'(0));
    subtract = sign_bit ^ invert;
  end

  // Move, then clamp to zero, the coordinate limit and, for a nonzero size, size - 1.
  always_comb begin
    pos_ext = W'(pos);
    sum     = subtract ? (pos_ext - W'(mag)) : (pos_ext + W'(mag));
    top     = (W'(1) << COORD_BITS) - W'(1);
    size_m1 = W'(size) - W'(1);
    if (sum[W-1]) begin
      clamped = '0;
    end else if (sum > top) begin
      clamped = top;
    end else begin
      clamped = sum;
    end
    if ((size != '0) && (clamped > size_m1)) begin
      clamped = size_m1;
    end
    pos_next = clamped[COORD_BITS-1:0];
  end

endmodule

/* design/ps2mc_cursor_regs.sv */
// Cursor state: position and button registers, updated by pending packets.
// Depends on ps2mc_pkg and ps2mc_axis (one instance per axis).
`timescale 1ns / 1ps

module ps2mc_cursor_regs #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  ps2mc_pkg::packet_t              packet,
  input  logic [ps2mc_pkg::SIZE_BITS-1:0] screen_width,
  input  logic [ps2mc_pkg::SIZE_BITS-1:0] screen_height,
  output logic [COORD_BITS-1:0]           pos_x_nxt,
  output logic [COORD_BITS-1:0]           pos_y_nxt,
  output logic [2:0]                      buttons_nxt
);
  import ps2mc_pkg::*;

  logic [COORD_BITS-1:0] pos_x_r, pos_y_r;
  logic [COORD_BITS-1:0] moved_x, moved_y;
  logic [2:0]            buttons_r;
  logic                  apply;

  ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .pos       (pos_x_r),
    .move_byte (packet.x_move),
    .sign_bit  (packet.header[HDR_X_SIGN]),
    .ovf_bit   (packet.header[HDR_X_OVF]),
    .invert    (1'b0),
    .size      (screen_width),
    .pos_next  (moved_x)
  );

  // Y is inverted so that down is positive.
  ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .pos       (pos_y_r),
    .move_byte (packet.y_move),
    .sign_bit  (packet.header[HDR_Y_SIGN]),
    .ovf_bit   (packet.header[HDR_Y_OVF]),
    .invert    (1'b1),
    .size      (screen_height),
    .pos_next  (moved_y)
  );

  // A pending packet takes effect on the next byte transfer.
  always_comb begin
    apply       = accept && packet.pending;
    pos_x_nxt   = apply ? moved_x : pos_x_r;
    pos_y_nxt   = apply ? moved_y : pos_y_r;
    buttons_nxt = apply ? packet.header[2:0] : buttons_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r   <= '0;
      pos_y_r   <= '0;
      buttons_r <= '0;
    end else begin
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      buttons_r <= buttons_nxt;
    end
  end

  // A transfer without a pending packet leaves the cursor where it was.
  a_hold_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !packet.pending) |=> ($stable(pos_x_r) && $stable(pos_y_r)))
    else $error("cursor moved without a pending packet");

  // Applying a packet latches its button bits.
  a_buttons: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && packet.pending) |=> (buttons_r == $past(packet.header[2:0])))
    else $error("buttons not latched from applied packet");

endmodule

/* design/ps2_mouse_packet_cursor.sv */
// Top level of the PS/2 mouse packet cursor block.
// Depends on ps2mc_pkg, ps2mc_framer, ps2mc_cursor_regs and ps2mc_axis.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the input channel (in_valid/in_stall, in_rx_byte) carries
// one byte from the mouse. Bytes are framed into header, X and Y packets; a
// header must have bit 3 set or it is dropped. A complete packet is applied
// on the following byte transfer, before that byte is framed.
// Every input transfer produces exactly one result transfer on the output
// channel (out_valid/out_stall): cursor X/Y and the three button bits.
// The result is in the output register in the cycle after the input
// transfer. Throughput is one byte per cycle while the receiver does not
// stall, set by the single add-and-clamp path per axis between the state and
// output registers. On a stall the held result stays on the outputs and
// in_stall rises, so no new byte is taken until the result is taken.
// Synchronous reset clears framing, cursor (0,0), buttons and the output
// valid, and loads screen width 1024 and height 768. The user must write the
// size registers (cfg_wr_en/cfg_index/cfg_wdata) only while the block is idle;
// this is not enforced. A size of zero removes the upper clamp on that axis.

module ps2_mouse_packet_cursor #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [ps2mc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [ps2mc_pkg::SIZE_BITS-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ps2mc_pkg::BYTE_BITS-1:0]      in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ps2mc_pkg::CURSOR_BITS-1:0]    out_cursor_x,
  output logic [ps2mc_pkg::CURSOR_BITS-1:0]    out_cursor_y,
  output logic                                 out_button_left,
  output logic                                 out_button_middle,
  output logic                                 out_button_right
);
  import ps2mc_pkg::*;

  localparam int OW = (COORD_BITS > CURSOR_BITS) ? COORD_BITS : CURSOR_BITS;

  logic [SIZE_BITS-1:0]   width_r, height_r;
  logic                   accept;
  logic                   out_valid_r, out_valid_nxt;
  packet_t                packet;
  logic [COORD_BITS-1:0]  pos_x_nxt, pos_y_nxt;
  logic [2:0]             buttons_nxt;
  logic [OW-1:0]          x_wide, y_wide;
  logic [CURSOR_BITS-1:0] cursor_x_r, cursor_y_r;
  logic [2:0]             buttons_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RST;
      height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input is taken unless a result is waiting on a stalled receiver.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  ps2mc_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .packet  (packet)
  );

  ps2mc_cursor_regs #(.COORD_BITS(COORD_BITS)) u_cursor (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .packet        (packet),
    .screen_width  (width_r),
    .screen_height (height_r),
    .pos_x_nxt     (pos_x_nxt),
    .pos_y_nxt     (pos_y_nxt),
    .buttons_nxt   (buttons_nxt)
  );

  // Output valid: set by a transfer in, cleared once the result is taken.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    x_wide = OW'(pos_x_nxt);
    y_wide = OW'(pos_y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
      buttons_r  <= '0;
    end else if (accept) begin
      cursor_x_r <= x_wide[CURSOR_BITS-1:0];
      cursor_y_r <= y_wide[CURSOR_BITS-1:0];
      buttons_r  <= buttons_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_x      = cursor_x_r;
  assign out_cursor_y      = cursor_y_r;
  assign out_button_left   = buttons_r[HDR_BTN_LEFT];
  assign out_button_middle = buttons_r[HDR_BTN_MIDDLE];
  assign out_button_right  = buttons_r[HDR_BTN_RIGHT];

  // Every input transfer leaves a result waiting.
  a_result_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("input transfer produced no result");

  // The result register changes only on an input transfer.
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(cursor_x_r) && $stable(cursor_y_r) && $stable(buttons_r)))
    else $error("result changed without an input transfer");

endmodule
